### rtl/twgg_pkg.sv
`timescale 1ns / 1ps

package twgg_pkg;

  localparam int MOTOR_COUNT      = 6;
  localparam int SINE_TABLE_DEPTH = 256;

  localparam int MOT_W  = $clog2(MOTOR_COUNT);
  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int AMP_W  = 15;
  localparam int DIST_W = 15;
  localparam int POS_W  = 16;
  localparam int PH_W   = 16;
  localparam int SIN_W  = 16;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 3;

  // gain factor (i + 5), then amplitude * factor, then * sine
  localparam int GF_W   = $clog2(MOTOR_COUNT + 5);
  localparam int GAIN_W = AMP_W + GF_W;
  localparam int PROD_W = GAIN_W + SIN_W + 1;
  localparam int N_W    = PROD_W - 15;
  localparam int Q_W    = N_W - 2;
  localparam int WAVE_W = Q_W + 1;
  localparam int SUM_W  = ((WAVE_W > POS_W) ? WAVE_W : POS_W) + 1;

  // divide by 5: multiply by floor(2^24 / 5), one correction step
  localparam int RECIP_W  = 22;
  localparam int RECIP_SH = 24;
  localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'((64'd1 << RECIP_SH) / 64'd5);

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(81920);
  localparam logic signed [18:0] RAD_TO_TURN = 19'sd166886;

  localparam logic [CIDX_W-1:0] REG_WALK_AMP  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SWIM_AMP  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_PH_STEP   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_SURFACE   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_DIVE      = 3'd4;
  localparam logic [CIDX_W-1:0] REG_POS_MIN   = 3'd5;
  localparam logic [CIDX_W-1:0] REG_POS_MAX   = 3'd6;
  localparam logic [CIDX_W-1:0] REG_AUTO      = 3'd7;

  localparam logic [MOT_W-1:0] LAST_MOTOR = MOT_W'(MOTOR_COUNT - 1);

  typedef struct packed {
    logic             load;
    logic             prep;
    logic             issue;
    logic [MOT_W-1:0] motor;
  } twgg_cmd_t;

  typedef struct packed {
    logic last_done;
  } twgg_status_t;

  function automatic logic signed [SIN_W-1:0] sine_q14(input int unsigned idx);
    logic [63:0] t;
    logic [1:0]  q;
    logic [63:0] r;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] u;
    logic [63:0] w;
    logic [63:0] s;
    logic [63:0] m;
    t  = 64'(idx) << (32 - IDX_W);
    q  = t[31:30];
    r  = {34'd0, t[29:0]};
    z  = q[0] ? (64'd1073741824 - r) : r;
    z2 = (z * z) >> 30;
    u  = 64'd686590538 - ((64'd74859813 * z2) >> 30);
    w  = 64'd1685472549 - ((u * z2) >> 30);
    s  = (w * z) >> 30;
    m  = (s + 64'd32768) >> 16;
    return q[1] ? -SIN_W'(m) : SIN_W'(m);
  endfunction

  function automatic logic [PH_W-1:0] phase_offset(input int unsigned m);
    return PH_W'((64'(m) * 64'd65536) / MOTOR_COUNT);
  endfunction

endpackage

### rtl/travelling_wave_gait_generator_top.sv
`timescale 1ns / 1ps
// A new transaction is taken only after the previous result is handed out; the motors
//   go one per cycle through a shared sine table, multiply and divide-by-5 pipeline.
// Input is taken only while idle; the result holds until the output transaction.
// Reset (rst, synchronous, active high): registers to defaults, phase 0, walking,
//   all held targets 0.

module travelling_wave_gait_generator_top import twgg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write_en,
  input  logic [CIDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [DIST_W-1:0]       left_distance,
  input  logic [DIST_W-1:0]       right_distance,
  input  logic signed [POS_W-1:0] elevation,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] motor_pos_0,
  output logic signed [POS_W-1:0] motor_pos_1,
  output logic signed [POS_W-1:0] motor_pos_2,
  output logic signed [POS_W-1:0] motor_pos_3,
  output logic signed [POS_W-1:0] motor_pos_4,
  output logic signed [POS_W-1:0] motor_pos_5,
  output logic                    swimming
);

  twgg_cmd_t               cmd;
  twgg_status_t            status;
  logic signed [POS_W-1:0] held [MOTOR_COUNT];

  twgg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  twgg_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .left_distance  (left_distance),
    .right_distance (right_distance),
    .elevation      (elevation),
    .held           (held),
    .swim_mode      (swimming)
  );

  assign motor_pos_0 = held[0];
  assign motor_pos_1 = held[1];
  assign motor_pos_2 = held[2];
  assign motor_pos_3 = held[3];
  assign motor_pos_4 = held[4];
  assign motor_pos_5 = held[5];

endmodule

### rtl/twgg_ctrl.sv
`timescale 1ns / 1ps

module twgg_ctrl import twgg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  twgg_status_t status,
  output twgg_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [MOT_W-1:0] motor;
  logic [MOT_W-1:0] motor_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    motor_next = motor;
    cmd.load   = 1'b0;
    cmd.prep   = 1'b0;
    cmd.issue  = 1'b0;
    cmd.motor  = motor;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        motor_next = '0;
        state_next = S_RUN;
      end
      S_RUN: begin
        cmd.issue  = 1'b1;
        motor_next = motor + MOT_W'(1);
        if (motor == LAST_MOTOR) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (status.last_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      motor <= '0;
    end else begin
      state <= state_next;
      motor <= motor_next;
    end
  end

`ifndef ASSERT_OFF
  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_PREP)
    else $error("accepted transaction did not start preparation");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN && motor == LAST_MOTOR |=> state == S_DRAIN)
    else $error("issue did not stop after last motor");

  a_done_drain: assert property (@(posedge clk) disable iff (rst)
    status.last_done |-> state == S_DRAIN)
    else $error("last motor finished outside drain");

  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
`endif

endmodule

### rtl/twgg_datapath.sv
`timescale 1ns / 1ps

module twgg_datapath import twgg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  twgg_cmd_t                cmd,
  output twgg_status_t             status,
  input  logic                     cfg_write_en,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic [DIST_W-1:0]        left_distance,
  input  logic [DIST_W-1:0]        right_distance,
  input  logic signed [POS_W-1:0]  elevation,
  output logic signed [POS_W-1:0]  held [MOTOR_COUNT],
  output logic                     swim_mode
);

  // configuration
  logic [AMP_W-1:0]        walk_amp;
  logic [AMP_W-1:0]        swim_amp;
  logic [PH_W-1:0]         phase_step;
  logic signed [POS_W-1:0] surface_level;
  logic signed [POS_W-1:0] dive_level;
  logic signed [POS_W-1:0] pos_min;
  logic signed [POS_W-1:0] pos_max;
  logic                    auto_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_amp      <= AMP_W'(2458);
      swim_amp      <= AMP_W'(4096);
      phase_step    <= PH_W'(2936);
      surface_level <= -POS_W'(12);
      dive_level    <= -POS_W'(61);
      pos_min       <= '0;
      pos_max       <= '0;
      auto_en       <= 1'b1;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_WALK_AMP: walk_amp      <= cfg_data[AMP_W-1:0];
        REG_SWIM_AMP: swim_amp      <= cfg_data[AMP_W-1:0];
        REG_PH_STEP:  phase_step    <= cfg_data[PH_W-1:0];
        REG_SURFACE:  surface_level <= cfg_data[POS_W-1:0];
        REG_DIVE:     dive_level    <= cfg_data[POS_W-1:0];
        REG_POS_MIN:  pos_min       <= cfg_data[POS_W-1:0];
        REG_POS_MAX:  pos_max       <= cfg_data[POS_W-1:0];
        REG_AUTO:     auto_en       <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // captured inputs
  logic [DIST_W-1:0]        left_r;
  logic [DIST_W-1:0]        right_r;
  logic signed [POS_W-1:0]  elev_r;
  logic signed [POS_W-1:0]  steer;
  logic [PH_W-1:0]          phase;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_r  <= left_distance;
      right_r <= right_distance;
      elev_r  <= elevation;
    end
  end

  // phase step and gait switch
  logic signed [34:0] reload_prod;
  logic [PH_W-1:0]    phase_stepped;

  assign reload_prod   = 35'(held[MOTOR_COUNT-1]) * 35'(RAD_TO_TURN) + 35'sd32768;
  assign phase_stepped = phase - phase_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      swim_mode <= 1'b0;
    end else if (cmd.prep && auto_en) begin
      if (swim_mode && (elev_r > surface_level)) begin
        swim_mode <= 1'b0;
        phase     <= reload_prod[31:16];
      end else begin
        phase <= phase_stepped;
        if (!swim_mode && (elev_r < dive_level)) begin
          swim_mode <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      steer <= POS_W'($signed({1'b0, right_r}) - $signed({1'b0, left_r}));
    end
  end

  // constant tables
  logic signed [SIN_W-1:0] sine_rom [SINE_TABLE_DEPTH];
  logic [PH_W-1:0]         offset_rom [MOTOR_COUNT];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
    assign sine_rom[g] = sine_q14(g);
  end

  for (genvar g = 0; g < MOTOR_COUNT; g++) begin : g_offset
    assign offset_rom[g] = phase_offset(g);
  end

  // stage 1: table lookup and gain
  logic [PH_W-1:0]   mot_phase;
  logic [AMP_W-1:0]  amp_sel;
  logic [GF_W-1:0]   gain_factor;

  assign mot_phase   = phase + offset_rom[cmd.motor];
  assign amp_sel     = swim_mode ? swim_amp : walk_amp;
  assign gain_factor = GF_W'(cmd.motor) + GF_W'(5);

  logic                    s1_valid;
  logic [MOT_W-1:0]        s1_mot;
  logic signed [SIN_W-1:0] s1_sin;
  logic [GAIN_W-1:0]       s1_gain;

  always_ff @(posedge clk) begin
    s1_mot  <= cmd.motor;
    s1_sin  <= sine_rom[mot_phase[PH_W-1 -: IDX_W]];
    s1_gain <= GAIN_W'(amp_sel * gain_factor);
  end

  // stage 2: wave product
  logic                     s2_valid;
  logic [MOT_W-1:0]         s2_mot;
  logic signed [PROD_W-1:0] s2_prod;

  always_ff @(posedge clk) begin
    s2_mot  <= s1_mot;
    s2_prod <= $signed({1'b0, s1_gain}) * s1_sin;
  end

  // stage 3: magnitude, round, divide by 32768
  logic [PROD_W-1:0] mag;
  logic [PROD_W-1:0] mag_rnd;

  assign mag     = s2_prod[PROD_W-1] ? PROD_W'(-s2_prod) : PROD_W'(s2_prod);
  assign mag_rnd = mag + ROUND_HALF;

  logic             s3_valid;
  logic [MOT_W-1:0] s3_mot;
  logic             s3_neg;
  logic [N_W-1:0]   s3_n;

  always_ff @(posedge clk) begin
    s3_mot <= s2_mot;
    s3_neg <= s2_prod[PROD_W-1];
    s3_n   <= mag_rnd[PROD_W-1:15];
  end

  // stage 4: reciprocal estimate of n / 5
  logic [N_W+RECIP_W-1:0] recip_prod;

  assign recip_prod = (N_W + RECIP_W)'(s3_n) * (N_W + RECIP_W)'(RECIP_5);

  logic             s4_valid;
  logic [MOT_W-1:0] s4_mot;
  logic             s4_neg;
  logic [N_W-1:0]   s4_n;
  logic [Q_W-1:0]   s4_q0;

  always_ff @(posedge clk) begin
    s4_mot <= s3_mot;
    s4_neg <= s3_neg;
    s4_n   <= s3_n;
    s4_q0  <= recip_prod[RECIP_SH +: Q_W];
  end

  // stage 5: correction and sign
  logic [N_W-1:0] five_q;
  logic [N_W-1:0] rem;
  logic [Q_W-1:0] quot;

  assign five_q = (N_W'(s4_q0) << 2) + N_W'(s4_q0);
  assign rem    = s4_n - five_q;
  assign quot   = (rem >= N_W'(5)) ? (s4_q0 + Q_W'(1)) : s4_q0;

  logic                     s5_valid;
  logic [MOT_W-1:0]         s5_mot;
  logic signed [WAVE_W-1:0] s5_wave;

  always_ff @(posedge clk) begin
    s5_mot  <= s4_mot;
    s5_wave <= s4_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  // stage 6: steer and saturate (or keep the held value when auto is off), clamp, store
  logic signed [SUM_W-1:0] sum;
  logic signed [POS_W-1:0] sat;
  logic signed [POS_W-1:0] src;
  logic signed [POS_W-1:0] clamped;
  logic                    clamp_on;

  assign sum      = SUM_W'(s5_wave) + SUM_W'(steer);
  assign clamp_on = !(pos_min > pos_max) && !((pos_min == '0) && (pos_max == '0));

  always_comb begin
    if (sum > SUM_W'(32767)) begin
      sat = POS_W'(32767);
    end else if (sum < -SUM_W'(32768)) begin
      sat = POS_W'(-32768);
    end else begin
      sat = sum[POS_W-1:0];
    end
    src = auto_en ? sat : held[s5_mot];
    if (clamp_on && (src < pos_min)) begin
      clamped = pos_min;
    end else if (clamp_on && (src > pos_max)) begin
      clamped = pos_max;
    end else begin
      clamped = src;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        held[i] <= '0;
      end
    end else if (s5_valid) begin
      held[s5_mot] <= clamped;
    end
  end

  assign status.last_done = s5_valid && (s5_mot == LAST_MOTOR);

endmodule

### tb/sv/travelling_wave_gait_generator_top_tb.sv
`timescale 1ns / 1ps

module travelling_wave_gait_generator_top_tb;
  import twgg_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ROUNDS         = 10;
  localparam int ROUND_TICKS    = 153;
  localparam int PLAN_LEN       = 37;
  localparam int DRAIN_CYCLES   = 16;

  typedef struct packed {
    logic [MOTOR_COUNT-1:0][POS_W-1:0] pos;
    logic                              swim;
  } gait_result_t;

  typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

  // typed rows expect every motor at pos
  typedef struct {
    row_kind_t         kind;
    logic [CIDX_W-1:0] reg_idx;
    int                value;
    int                left;
    int                right;
    int                elev;
    bit                typed;
    int                pos;
    bit                swim;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_write_en;
  logic [CIDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [DIST_W-1:0]       left_distance;
  logic [DIST_W-1:0]       right_distance;
  logic signed [POS_W-1:0] elevation;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [POS_W-1:0] motor_pos_0;
  logic signed [POS_W-1:0] motor_pos_1;
  logic signed [POS_W-1:0] motor_pos_2;
  logic signed [POS_W-1:0] motor_pos_3;
  logic signed [POS_W-1:0] motor_pos_4;
  logic signed [POS_W-1:0] motor_pos_5;
  logic                    swimming;

  logic [MOTOR_COUNT-1:0][POS_W-1:0] seen_pos;

  // predictor copy of registers and state
  logic [AMP_W-1:0]        walk_amp;
  logic [AMP_W-1:0]        swim_amp;
  logic [PH_W-1:0]         step_size;
  logic signed [POS_W-1:0] surf_lvl;
  logic signed [POS_W-1:0] dive_lvl;
  logic signed [POS_W-1:0] lim_lo;
  logic signed [POS_W-1:0] lim_hi;
  logic                    auto_on;
  logic [PH_W-1:0]         wave_ph;
  logic                    swim_st;
  logic signed [POS_W-1:0] held [MOTOR_COUNT];

  gait_result_t awaited_targets [$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  int           elev_track = 0;
  bit           src_quiet = 1'b0;
  bit           sink_quiet = 1'b0;

  plan_row_t directed_plan [PLAN_LEN] = '{
    '{ROW_WRITE, REG_AUTO,          0,     0,     0,      0, 0,   0, 0},
    '{ROW_TICK,  0,                 0,     0,     0,      0, 1,   0, 0},
    '{ROW_TICK,  0,                 0, 32767,     0, -32768, 1,   0, 0},
    '{ROW_WRITE, REG_POS_MIN,     100,     0,     0,      0, 0,   0, 0},
    '{ROW_WRITE, REG_POS_MAX,     100,     0,     0,      0, 0,   0, 0},
    '{ROW_TICK,  0,                 0,     0, 32767,  32767, 1, 100, 0},
    '{ROW_WRITE, REG_POS_MIN,  -32768,     0,     0,      0, 0,   0, 0},
    '{ROW_WRITE, REG_POS_MAX,   32767,     0,     0,      0, 0,   0, 0},
    '{ROW_WRITE, REG_AUTO,          1,     0,     0,      0, 0,   0, 0},
    '{ROW_TICK,  0,                 0,     0, 32767,  32767, 0,   0, 0},
    '{ROW_TICK,  0,                 0, 32767,     0, -32768, 0,   0, 0},
    '{ROW_TICK,  0,                 0,   100,    90,    -12, 0,   0, 0},
    '{ROW_TICK,  0,                 0,     5,     9,    -11, 0,   0, 0},
    '{ROW_TICK,  0,                 0,     0,     0,    -61, 0,   0, 0},
    '{ROW_TICK,  0,                 0,     0,     0,    -62, 0,   0, 0},
    '{ROW_TICK,  0,                 0, 16383, 16384,  32767, 0,   0, 0},
    '{ROW_WRITE, REG_WALK_AMP,  32767,     0,     0,      0, 0,   0, 0},
    '{ROW_WRITE, REG_SWIM_AMP,  32767,     0,     0,      0, 0,   0, 0},
    '{ROW_WRITE, REG_PH_STEP,   65535,     0,     0,      0, 0,   0, 0},
    '{ROW_WRITE, REG_POS_MIN,       0,     0,     0,      0, 0,   0, 0},
    '{ROW_WRITE, REG_POS_MAX,       0,     0,     0,      0, 0,   0, 0},
    '{ROW_TICK,  0,                 0,     0, 32767,      0, 0,   0, 0},
    '{ROW_TICK,  0,                 0, 32767,     0,   -100, 0,   0, 0},
    '{ROW_TICK,  0,                 0, 32767,     0,   -100, 0,   0, 0},
    '{ROW_TICK,  0,                 0,     0,     0,      0, 0,   0, 0},
    '{ROW_TICK,  0,                 0, 12345,    54, -32768, 0,   0, 0},
    '{ROW_WRITE, REG_POS_MIN,     200,     0,     0,      0, 0,   0, 0},
    '{ROW_WRITE, REG_POS_MAX,    -200,     0,     0,      0, 0,   0, 0},
    '{ROW_TICK,  0,                 0,  1000,     0,      0, 0,   0, 0},
    '{ROW_TICK,  0,                 0,     0,  1000, -32768, 0,   0, 0},
    '{ROW_WRITE, REG_PH_STEP,       0,     0,     0,      0, 0,   0, 0},
    '{ROW_WRITE, REG_WALK_AMP,      0,     0,     0,      0, 0,   0, 0},
    '{ROW_WRITE, REG_SWIM_AMP,      0,     0,     0,      0, 0,   0, 0},
    '{ROW_WRITE, REG_SURFACE,   32767,     0,     0,      0, 0,   0, 0},
    '{ROW_WRITE, REG_DIVE,     -32768,     0,     0,      0, 0,   0, 0},
    '{ROW_TICK,  0,                 0, 32767, 32767,  32767, 0,   0, 0},
    '{ROW_TICK,  0,                 0,     0,     0, -32768, 0,   0, 0}
  };

  travelling_wave_gait_generator_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .left_distance  (left_distance),
    .right_distance (right_distance),
    .elevation      (elevation),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .motor_pos_0    (motor_pos_0),
    .motor_pos_1    (motor_pos_1),
    .motor_pos_2    (motor_pos_2),
    .motor_pos_3    (motor_pos_3),
    .motor_pos_4    (motor_pos_4),
    .motor_pos_5    (motor_pos_5),
    .swimming       (swimming)
  );

  assign seen_pos = {motor_pos_5, motor_pos_4, motor_pos_3,
                     motor_pos_2, motor_pos_1, motor_pos_0};

  always #1 clk = ~clk;

  // Q14 sine of a 16-bit turn fraction via quantized table angle and Q30 polynomial
  function automatic int gait_sine(input logic [PH_W-1:0] p);
    longint unsigned idx, t, quad, rest, z, z2, u, w, s, m;
    idx  = (64'(p) * SINE_TABLE_DEPTH) >> 16;
    t    = (idx << 32) / SINE_TABLE_DEPTH;
    quad = (t >> 30) & 64'd3;
    rest = t & 64'h3FFF_FFFF;
    z    = quad[0] ? (64'd1073741824 - rest) : rest;
    z2   = (z * z) >> 30;
    u    = 64'd686590538 - ((64'd74859813 * z2) >> 30);
    w    = 64'd1685472549 - ((u * z2) >> 30);
    s    = (w * z) >> 30;
    m    = (s + 64'd32768) >> 16;
    return quad[1] ? -int'(m) : int'(m);
  endfunction

  function automatic gait_result_t advance_gait(input logic [DIST_W-1:0] l,
                                                input logic [DIST_W-1:0] r,
                                                input logic signed [POS_W-1:0] e);
    gait_result_t    res;
    longint          steer, amp, prod, mag, wave, v, reload;
    logic [PH_W-1:0] off;
    int              i;
    res = '0;
    if (auto_on) begin
      steer = longint'(r) - longint'(l);
      wave_ph = wave_ph - step_size;
      if (swim_st && e > surf_lvl) begin
        // back on land: phase resumes from the last motor's angle
        reload  = longint'(held[MOTOR_COUNT-1]) * RAD_TO_TURN + 32768;
        swim_st = 1'b0;
        wave_ph = reload[31:16];
      end else if (!swim_st && e < dive_lvl) begin
        swim_st = 1'b1;
      end
      amp = swim_st ? longint'(swim_amp) : longint'(walk_amp);
      for (i = 0; i < MOTOR_COUNT; i++) begin
        off  = PH_W'((longint'(i) * 65536) / MOTOR_COUNT);
        prod = amp * longint'(gait_sine(wave_ph + off)) * longint'(i + 5);
        mag  = (prod < 0) ? -prod : prod;
        wave = (mag + 81920) / 163840;
        if (prod < 0) wave = -wave;
        v = wave + steer;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        held[i] = POS_W'(v);
      end
    end
    for (i = 0; i < MOTOR_COUNT; i++) begin
      if (!(lim_lo > lim_hi || (lim_lo == 0 && lim_hi == 0))) begin
        if (held[i] < lim_lo) held[i] = lim_lo;
        else if (held[i] > lim_hi) held[i] = lim_hi;
      end
      res.pos[i] = held[i];
    end
    res.swim = swim_st;
    return res;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CFG_W-1:0] pick_amp();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'(32767);
      2:       return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(500, 8000));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    case (idx)
      REG_WALK_AMP: walk_amp  = data[AMP_W-1:0];
      REG_SWIM_AMP: swim_amp  = data[AMP_W-1:0];
      REG_PH_STEP:  step_size = data;
      REG_SURFACE:  surf_lvl  = data;
      REG_DIVE:     dive_lvl  = data;
      REG_POS_MIN:  lim_lo    = data;
      REG_POS_MAX:  lim_hi    = data;
      REG_AUTO:     auto_on   = data[0];
      default: ;
    endcase
  endtask

  task automatic send_tick(input int l, input int r, input int e,
                           input bit typed, input gait_result_t typed_res);
    gait_result_t pred;
    int           gap;
    gap = pick_gap(src_quiet);
    cfg_write_en <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    left_distance  <= DIST_W'(l);
    right_distance <= DIST_W'(r);
    elevation      <= POS_W'(e);
    do @(posedge clk); while (in_stall);
    pred = advance_gait(DIST_W'(l), DIST_W'(r), POS_W'(e));
    awaited_targets.push_back(typed ? typed_res : pred);
  endtask

  task automatic drain();
    in_valid     <= 1'b0;
    cfg_write_en <= 1'b0;
    while (awaited_targets.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic random_settings();
    int surf, dive, lo, hi;
    if ($urandom_range(0, 4) == 0) begin
      surf = int'($urandom_range(0, 65535)) - 32768;
      dive = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      surf = int'($urandom_range(0, 8000)) - 4000;
      dive = surf - int'($urandom_range(0, 3000));
    end
    case ($urandom_range(0, 3))
      0: begin
        lo = 0;
        hi = 0;
      end
      1: begin
        hi = int'($urandom_range(0, 60000)) - 30000;
        lo = hi + int'($urandom_range(1, 2000));
      end
      default: begin
        lo = int'($urandom_range(0, 40000)) - 32768;
        hi = lo + int'($urandom_range(0, 30000));
        if (hi > 32767) hi = 32767;
        if ($urandom_range(0, 7) == 0) hi = lo;
      end
    endcase
    write_reg(REG_WALK_AMP, pick_amp());
    write_reg(REG_SWIM_AMP, pick_amp());
    case ($urandom_range(0, 9))
      0:       write_reg(REG_PH_STEP, '0);
      1:       write_reg(REG_PH_STEP, '1);
      default: write_reg(REG_PH_STEP, CFG_W'($urandom));
    endcase
    write_reg(REG_SURFACE, CFG_W'(surf));
    write_reg(REG_DIVE, CFG_W'(dive));
    write_reg(REG_POS_MIN, CFG_W'(lo));
    write_reg(REG_POS_MAX, CFG_W'(hi));
    write_reg(REG_AUTO, CFG_W'($urandom_range(0, 6) != 0));
  endtask

  task automatic random_tick();
    int l, r, e, base;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        l = $urandom_range(0, 32767);
        r = $urandom_range(0, 32767);
      end
      5, 6, 7: begin
        base = $urandom_range(200, 32567);
        l = base;
        r = base + int'($urandom_range(0, 400)) - 200;
      end
      8: begin
        l = $urandom_range(0, 1) ? 32767 : 0;
        r = $urandom_range(0, 1) ? 32767 : 0;
      end
      default: begin
        l = $urandom_range(0, 32767);
        r = l;
      end
    endcase
    case ($urandom_range(0, 9))
      0: e = int'($urandom_range(0, 65535)) - 32768;
      1: e = $urandom_range(0, 1) ? 32767 : -32768;
      2, 3: begin
        base = $urandom_range(0, 1) ? int'(surf_lvl) : int'(dive_lvl);
        e = base + int'($urandom_range(0, 2)) - 1;
      end
      default: begin
        // drift toward the opposite gait so transitions keep happening
        elev_track += (swim_st ? 1 : -1) * int'($urandom_range(1, 500));
        if (elev_track > 32767) elev_track = 32767;
        if (elev_track < -32768) elev_track = -32768;
        e = elev_track;
      end
    endcase
    send_tick(l, r, e, 1'b0, '0);
  endtask

  always @(posedge clk) begin : result_check
    gait_result_t want;
    int           m;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_targets.size() == 0) begin
        report_mismatch("result with nothing pending, swimming", -1, int'(swimming));
      end else begin
        want = awaited_targets.pop_front();
        for (m = 0; m < MOTOR_COUNT; m++) begin
          if (want.pos[m] !== seen_pos[m])
            report_mismatch($sformatf("motor_pos_%0d", m),
                            int'($signed(want.pos[m])), int'($signed(seen_pos[m])));
        end
        if (want.swim !== swimming)
          report_mismatch("swimming", int'(want.swim), int'(swimming));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("travelling_wave_gait_generator_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      hold = pick_gap(sink_quiet);
      if (hold == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin : tick_source
    gait_result_t typed_res;
    int           k, n, i;
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    left_distance  = '0;
    right_distance = '0;
    elevation      = '0;
    walk_amp  = AMP_W'(2458);
    swim_amp  = AMP_W'(4096);
    step_size = PH_W'(2936);
    surf_lvl  = -POS_W'(12);
    dive_lvl  = -POS_W'(61);
    lim_lo    = '0;
    lim_hi    = '0;
    auto_on   = 1'b1;
    wave_ph   = '0;
    swim_st   = 1'b0;
    for (i = 0; i < MOTOR_COUNT; i++) held[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < PLAN_LEN; k++) begin
      if (directed_plan[k].kind == ROW_WRITE) begin
        drain();
        write_reg(directed_plan[k].reg_idx, CFG_W'(directed_plan[k].value));
      end else begin
        typed_res.pos  = {MOTOR_COUNT{POS_W'(directed_plan[k].pos)}};
        typed_res.swim = directed_plan[k].swim;
        send_tick(directed_plan[k].left, directed_plan[k].right, directed_plan[k].elev,
                  directed_plan[k].typed, typed_res);
      end
    end

    for (k = 0; k < ROUNDS; k++) begin
      drain();
      random_settings();
      src_quiet  = ($urandom_range(0, 4) == 0);
      sink_quiet = ($urandom_range(0, 4) == 0);
      for (n = 0; n < ROUND_TICKS; n++) random_tick();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("travelling_wave_gait_generator_top regression: pass");
    end else begin
      $display("travelling_wave_gait_generator_top regression: fail");
    end
    $finish;
  end

endmodule
